// File: sv/dqpb_pkg.sv
package dqpb_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR,
    ST_LEN,
    ST_DATA,
    ST_TRL
  } state_t;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] flags_word;
    logic [15:0] query_type;
    logic [15:0] query_class;
  } cfg_t;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FLAGS  = 2'd0;
  localparam logic [1:0] REG_QTYPE  = 2'd1;
  localparam logic [1:0] REG_QCLASS = 2'd2;

  localparam logic [15:0] FLAGS_RESET  = 16'h0100;
  localparam logic [15:0] QTYPE_RESET  = 16'h0001;
  localparam logic [15:0] QCLASS_RESET = 16'h0001;

  localparam logic [7:0] SEP_CHAR = 8'h2E;

  // last byte position of header and trailer bursts
  localparam logic [3:0] HDR_LAST = 4'd11;
  localparam logic [2:0] TRL_LAST = 3'd4;

endpackage

// File: sv/dqpb_cfg.sv
module dqpb_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output dqpb_pkg::cfg_t      cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flags_word  <= dqpb_pkg::FLAGS_RESET;
      cfg.query_type  <= dqpb_pkg::QTYPE_RESET;
      cfg.query_class <= dqpb_pkg::QCLASS_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        dqpb_pkg::REG_FLAGS:  cfg.flags_word  <= pwdata[15:0];
        dqpb_pkg::REG_QTYPE:  cfg.query_type  <= pwdata[15:0];
        dqpb_pkg::REG_QCLASS: cfg.query_class <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dqpb_pkg::REG_FLAGS:  prdata = {16'h0000, cfg.flags_word};
      dqpb_pkg::REG_QTYPE:  prdata = {16'h0000, cfg.query_type};
      dqpb_pkg::REG_QCLASS: prdata = {16'h0000, cfg.query_class};
      default:              prdata = 32'h0000_0000;
    endcase
  end

endmodule

// File: sv/dqpb_seq.sv
module dqpb_seq #(
  parameter int LABEL_MAX = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  dqpb_pkg::cfg_t cfg,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [23:0]    s_tdata,
  input  logic           s_tuser,
  input  logic           s_tlast,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast,
  output logic [1:0]     m_tuser
);

  localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
  localparam int CW = $clog2(LABEL_MAX + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  dqpb_pkg::state_t state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic [CW-1:0] cnt;
  logic          ovf;
  logic          last_q;
  logic          flush_q;
  logic [15:0]   qid_q;

  logic [7:0]    label_mem [LABEL_MAX];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  logic [7:0]    ch;
  logic          s_fire, is_sep, store, gen, slot;
  logic [CW-1:0] cnt_base, cnt_acc;
  logic          ovf_base;
  logic [PW-1:0] cnt_w, last_idx;
  logic          data_done;

  logic [7:0]    byte_sel;
  logic          run_sel, pend_sel, cut_sel;

  assign ch       = s_tdata[7:0];
  assign s_tready = (state == dqpb_pkg::ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign is_sep   = (ch == dqpb_pkg::SEP_CHAR);
  assign cnt_base = s_tuser ? '0 : cnt;
  assign ovf_base = s_tuser ? 1'b0 : ovf;
  assign store    = !is_sep && (cnt_base < CW'(LABEL_MAX));
  assign cnt_acc  = cnt_base + CW'(store);
  assign slot     = !m_tvalid || m_tready;
  assign gen      = slot && (state != dqpb_pkg::ST_IDLE);
  assign cnt_w    = PW'(cnt);
  assign last_idx = cnt_w - PW'(1);
  assign data_done = gen && (state == dqpb_pkg::ST_DATA) && (pos == last_idx);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dqpb_pkg::ST_IDLE: begin
        if (s_fire) begin
          priority if (s_tuser)                           state_next = dqpb_pkg::ST_HDR;
          else if ((is_sep || s_tlast) && cnt_acc != '0)  state_next = dqpb_pkg::ST_LEN;
          else if (s_tlast)                               state_next = dqpb_pkg::ST_TRL;
          else                                            state_next = dqpb_pkg::ST_IDLE;
        end
      end
      dqpb_pkg::ST_HDR: begin
        if (gen && pos[3:0] == dqpb_pkg::HDR_LAST) begin
          priority if (flush_q && cnt != '0) state_next = dqpb_pkg::ST_LEN;
          else if (last_q)                   state_next = dqpb_pkg::ST_TRL;
          else                               state_next = dqpb_pkg::ST_IDLE;
        end
      end
      dqpb_pkg::ST_LEN: begin
        if (gen) state_next = dqpb_pkg::ST_DATA;
      end
      dqpb_pkg::ST_DATA: begin
        if (data_done) state_next = last_q ? dqpb_pkg::ST_TRL : dqpb_pkg::ST_IDLE;
      end
      dqpb_pkg::ST_TRL: begin
        if (gen && pos[2:0] == dqpb_pkg::TRL_LAST) state_next = dqpb_pkg::ST_IDLE;
      end
      default: state_next = dqpb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_next != state) pos_next = '0;
    else if (gen)            pos_next = pos + PW'(1);
    else                     pos_next = pos;
  end

  // byte select for the current position
  always_comb begin
    byte_sel = 8'h00;
    run_sel  = 1'b0;
    pend_sel = 1'b0;
    cut_sel  = 1'b0;
    unique case (state)
      dqpb_pkg::ST_HDR: begin
        unique case (pos[3:0])
          4'd0:    byte_sel = qid_q[15:8];
          4'd1:    byte_sel = qid_q[7:0];
          4'd2:    byte_sel = cfg.flags_word[15:8];
          4'd3:    byte_sel = cfg.flags_word[7:0];
          4'd5:    byte_sel = 8'h01;
          default: byte_sel = 8'h00;
        endcase
        run_sel = (pos[3:0] == dqpb_pkg::HDR_LAST) && !(flush_q && cnt != '0) && !last_q;
      end
      dqpb_pkg::ST_LEN: begin
        byte_sel = 8'(cnt);
        cut_sel  = ovf;
      end
      dqpb_pkg::ST_DATA: begin
        byte_sel = rd_data;
        cut_sel  = ovf;
        run_sel  = (pos == last_idx) && !last_q;
      end
      dqpb_pkg::ST_TRL: begin
        unique case (pos[2:0])
          3'd1:    byte_sel = cfg.query_type[15:8];
          3'd2:    byte_sel = cfg.query_type[7:0];
          3'd3:    byte_sel = cfg.query_class[15:8];
          3'd4:    byte_sel = cfg.query_class[7:0];
          default: byte_sel = 8'h00;
        endcase
        run_sel  = (pos[2:0] == dqpb_pkg::TRL_LAST);
        pend_sel = (pos[2:0] == dqpb_pkg::TRL_LAST);
      end
      default: ;
    endcase
  end

  // prefetch: data for the byte at pos is registered in rd_data before pos reaches it
  always_comb begin
    if (state == dqpb_pkg::ST_DATA) begin
      if (gen && (pos + PW'(1)) < cnt_w) rd_addr = AW'(pos + PW'(1));
      else                               rd_addr = AW'(pos);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && store) label_mem[AW'(cnt_base)] <= ch;
    rd_data <= label_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dqpb_pkg::ST_IDLE;
      pos      <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      if (s_fire) begin
        cnt <= cnt_acc;
        ovf <= ovf_base || (!is_sep && !store);
      end else if (data_done) begin
        cnt <= '0;
        ovf <= 1'b0;
      end
      if (gen)           m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      last_q  <= s_tlast;
      flush_q <= is_sep || s_tlast;
      qid_q   <= s_tdata[23:8];
    end
    if (gen) begin
      m_tdata <= byte_sel;
      m_tlast <= run_sel;
      m_tuser <= {cut_sel, pend_sel};
    end
  end

endmodule

// File: sv/dns_query_packet_builder.sv
// channel   dir  beat contents
// s_*       in   tdata: name_char[7:0], query_id[23:8]; tuser: name_first; tlast: name_last
// m_*       out  tdata: out_byte[7:0]; tuser: packet_end[0], label_too_long[1]; tlast: run_end
// apb       in   0x0 flags_word, 0x4 query_type, 0x8 query_class (16 bits each)
//
// a character that is only buffered leaves the input ready; otherwise the input stays
// not ready while the byte sequencer runs: 12 bytes of header when name_first
// is set, 1 + n bytes for a label of n characters, 5 bytes of trailer
// the sequencer emits at most one byte per cycle into the output register and
// pauses whenever that register is full and m_tready is low
// rst is synchronous and active high; the label buffer itself is not cleared
module dns_query_packet_builder #(
  parameter int LABEL_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // name_char, query_id
  input  logic        s_tuser,   // name_first
  input  logic        s_tlast,   // name_last
  // packet bytes
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,   // run_end
  output logic [1:0]  m_tuser,   // packet_end, label_too_long
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  dqpb_pkg::cfg_t cfg;

  // register file, read back through prdata
  dqpb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // label buffer, byte counter and output register
  dqpb_seq #(
    .LABEL_MAX (LABEL_MAX)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // the packet's final byte always closes its run
  a_pend_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("packet end without run end");

  // the trailer never carries the cut flag
  a_pend_cut: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("label cut flag on trailer byte");

  // a header or trailer request keeps the input busy the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser || s_tlast) |=> !s_tready)
    else $error("input ready while packet bytes pending");

endmodule

// File: tb/sv/dns_query_packet_builder_tb.sv
`timescale 1ns / 100ps

module dns_query_packet_builder_tb;

  localparam int LABEL_MAX = 32;
  // longest legal quiet stretch is the forced receiver hold plus a long gap
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  // settle time after the last expected beat before touching registers or ending
  localparam int TAIL_WAIT = 20;
  localparam int RAND_ITEMS = 100;
  localparam int N_DIR = 21;
  localparam int MAX_PRINTED = 40;

  // how a directed row is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,  // against the predictor
    CHK_NONE,     // typed: the character is only buffered, no beat
    CHK_BARE      // typed: empty name at register defaults, header and trailer only
  } chk_kind_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        last;
    logic [15:0] qid;
  } name_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        first;
    logic        last;
    logic [15:0] qid;
    logic [7:0]  rep;
    chk_kind_t   kind;
  } name_row_t;

  // one packet byte as it should leave the block
  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       pkt_end;
    logic       cut;
  } pkt_beat_t;

  // header after the id, then the trailer, with flags, type and class at reset
  localparam logic [7:0] BARE_TAIL [15] = '{
    8'h01, 8'h00,                                // flags 0x0100
    8'h00, 8'h01,                                // one question
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,    // no answer, authority, additional
    8'h00,                                       // root label
    8'h00, 8'h01,                                // type 1
    8'h00, 8'h01                                 // class 1
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // name_char[7:0], query_id[23:8]
  logic        s_tuser;   // name_first
  logic        s_tlast;   // name_last
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte[7:0]
  logic        m_tlast;   // run_end
  logic [1:0]  m_tuser;   // packet_end[0], label_too_long[1]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dns_query_packet_builder #(
    .LABEL_MAX(LABEL_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the block's registers and label collector
  logic [15:0] cfg_flags;
  logic [15:0] cfg_qtype;
  logic [15:0] cfg_qclass;
  logic [7:0]  lbl_buf [LABEL_MAX];
  int          lbl_len;
  logic        lbl_cut;

  pkt_beat_t   step_beats [$];   // beats caused by the item just accepted
  pkt_beat_t   pkt_expect [$];   // beats still owed by the block, oldest first

  int          mismatches;
  int          items_sent;
  int          quiet_cycles;
  int          hold_ask;         // bumped by the sender to request a long receiver hold
  bit          tx_idle;
  bit          rx_idle;

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (mismatches < MAX_PRINTED)
      $display("%0t ns %s: got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic put_beat(input logic [7:0] data, input logic pkt_end, input logic cut);
    step_beats.push_back(pkt_beat_t'{data, 1'b0, pkt_end, cut});
  endtask

  // big-endian 16-bit field, packet end can only fall on the low byte
  task automatic put_word(input logic [15:0] w, input logic pkt_end);
    put_beat(w[15:8], 1'b0, 1'b0);
    put_beat(w[7:0], pkt_end, 1'b0);
  endtask

  // close the collected label: length byte then characters, nothing if empty
  task automatic flush_label();
    if (lbl_len != 0) begin
      put_beat(8'(lbl_len), 1'b0, lbl_cut);
      for (int i = 0; i < lbl_len; i++)
        put_beat(lbl_buf[i], 1'b0, lbl_cut);
    end
    lbl_len = 0;
    lbl_cut = 1'b0;
  endtask

  task automatic predict_query_step(input name_item_t it);
    pkt_beat_t b;
    step_beats.delete();
    if (it.first) begin
      // a new name drops any half-collected label
      lbl_len = 0;
      lbl_cut = 1'b0;
      put_word(it.qid, 1'b0);
      put_word(cfg_flags, 1'b0);
      put_word(16'd1, 1'b0);
      put_word(16'd0, 1'b0);
      put_word(16'd0, 1'b0);
      put_word(16'd0, 1'b0);
    end
    if (it.ch == dqpb_pkg::SEP_CHAR) begin
      flush_label();
    end else if (lbl_len < LABEL_MAX) begin
      lbl_buf[lbl_len] = it.ch;
      lbl_len++;
    end else begin
      lbl_cut = 1'b1;
    end
    if (it.last) begin
      flush_label();
      put_beat(8'h00, 1'b0, 1'b0);
      put_word(cfg_qtype, 1'b0);
      put_word(cfg_qclass, 1'b1);
    end
    if (step_beats.size() > 0) begin
      b = step_beats.pop_back();
      b.run_end = 1'b1;
      step_beats.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // any byte but the separator
  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == dqpb_pkg::SEP_CHAR);
    return c;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_char(input name_item_t it, input chk_kind_t kind);
    int gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {it.qid, it.ch};
    s_tuser  <= it.first;
    s_tlast  <= it.last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    // the predictor always runs so its label state tracks the block
    predict_query_step(it);
    case (kind)
      CHK_PREDICT: begin
        foreach (step_beats[i]) pkt_expect.push_back(step_beats[i]);
      end
      CHK_BARE: begin
        pkt_expect.push_back(pkt_beat_t'{it.qid[15:8], 1'b0, 1'b0, 1'b0});
        pkt_expect.push_back(pkt_beat_t'{it.qid[7:0], 1'b0, 1'b0, 1'b0});
        foreach (BARE_TAIL[i])
          pkt_expect.push_back(pkt_beat_t'{BARE_TAIL[i], i == 14, i == 14, 1'b0});
      end
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pkt_expect.size() != 0) @(posedge clk);
  endtask

  // setup then access; the register takes the value at the access edge
  task automatic apb_write(input logic [1:0] idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      dqpb_pkg::REG_FLAGS: cfg_flags  = val;
      dqpb_pkg::REG_QTYPE: cfg_qtype  = val;
      default:             cfg_qclass = val;
    endcase
    @(posedge clk);
  endtask

  // registers only change with the block idle and every beat delivered
  task automatic set_registers(input logic [15:0] flags, input logic [15:0] qtype,
                               input logic [15:0] qclass);
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    apb_write(dqpb_pkg::REG_FLAGS, flags);
    apb_write(dqpb_pkg::REG_QTYPE, qtype);
    apb_write(dqpb_pkg::REG_QCLASS, qclass);
  endtask

  // a dotted name with random content; now and then a restart mid-name
  task automatic send_random_name();
    name_item_t seq [$];
    name_item_t it;
    int nlab;
    int len;
    int r;
    nlab = $urandom_range(1, 4);
    for (int l = 0; l < nlab; l++) begin
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 6);
      else if (r < 88) len = $urandom_range(7, 20);
      else if (r < 93) len = 0;                   // empty label, double separator
      else len = $urandom_range(30, 36);          // around the label limit
      for (int c = 0; c < len; c++)
        seq.push_back(name_item_t'{label_char(), 1'b0, 1'b0, 16'($urandom)});
      // the final label ends either on its last character or on a trailing dot
      if (l != nlab - 1 || $urandom_range(0, 1) == 1)
        seq.push_back(name_item_t'{dqpb_pkg::SEP_CHAR, 1'b0, 1'b0, 16'($urandom)});
    end
    if (seq.size() == 0)
      seq.push_back(name_item_t'{dqpb_pkg::SEP_CHAR, 1'b0, 1'b0, 16'($urandom)});
    it = seq[0];
    it.first = 1'b1;
    seq[0] = it;
    it = seq[seq.size() - 1];
    it.last = 1'b1;
    seq[seq.size() - 1] = it;
    foreach (seq[i]) begin
      it = seq[i];
      if (i != 0 && $urandom_range(0, 99) < 3) it.first = 1'b1;
      send_char(it, CHK_PREDICT);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold on request
  // ---------------------------------------------------------------------------

  initial begin
    int hold_seen;
    hold_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pkt_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pkt_expect.size() == 0) begin
        note_mismatch("beat with nothing pending, out_byte", m_tdata, 8'h00);
      end else begin
        want = pkt_expect.pop_front();
        if (m_tdata !== want.data)
          note_mismatch("out_byte", m_tdata, want.data);
        if (m_tlast !== want.run_end)
          note_mismatch("run_end", 8'(m_tlast), 8'(want.run_end));
        if (m_tuser[0] !== want.pkt_end)
          note_mismatch("packet_end", 8'(m_tuser[0]), 8'(want.pkt_end));
        if (m_tuser[1] !== want.cut)
          note_mismatch("label_too_long", 8'(m_tuser[1]), 8'(want.cut));
      end
    end
  end

  // watchdog: too long without any beat or register access ends the run
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("dns_query_packet_builder: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    name_row_t  dir_rows [N_DIR];
    name_item_t it;
    int         phase_start;
    bit         paused;

    mismatches   = 0;
    items_sent   = 0;
    hold_ask     = 0;
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    paused       = 1'b0;
    cfg_flags    = dqpb_pkg::FLAGS_RESET;
    cfg_qtype    = dqpb_pkg::QTYPE_RESET;
    cfg_qclass   = dqpb_pkg::QCLASS_RESET;
    lbl_len      = 0;
    lbl_cut      = 1'b0;

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= 1'b0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;

    dir_rows = '{
      // empty name straight after reset: header and trailer at register defaults
      '{dqpb_pkg::SEP_CHAR, 1'b1, 1'b1, 16'hFFFF, 8'd1,  CHK_BARE},
      // header only, three ordinary characters incl. zero and all-ones
      '{8'h61,              1'b1, 1'b0, 16'h0000, 8'd1,  CHK_PREDICT},
      '{8'h00,              1'b0, 1'b0, 16'hFFFF, 8'd1,  CHK_NONE},
      '{8'hFF,              1'b0, 1'b0, 16'h0000, 8'd1,  CHK_NONE},
      '{dqpb_pkg::SEP_CHAR, 1'b0, 1'b0, 16'h0000, 8'd1,  CHK_PREDICT},
      // empty label is dropped
      '{dqpb_pkg::SEP_CHAR, 1'b0, 1'b0, 16'h0000, 8'd1,  CHK_NONE},
      '{8'h78,              1'b0, 1'b1, 16'h0000, 8'd1,  CHK_PREDICT},
      // characters with no header in front
      '{8'h71,              1'b0, 1'b0, 16'h0000, 8'd1,  CHK_NONE},
      '{8'h72,              1'b0, 1'b1, 16'h0000, 8'd1,  CHK_PREDICT},
      // restart in the middle of a name drops the partial label
      '{8'h61,              1'b1, 1'b0, 16'h1234, 8'd1,  CHK_PREDICT},
      '{8'h62,              1'b0, 1'b0, 16'h0000, 8'd1,  CHK_NONE},
      '{8'h63,              1'b1, 1'b0, 16'h8001, 8'd1,  CHK_PREDICT},
      '{dqpb_pkg::SEP_CHAR, 1'b0, 1'b1, 16'h0000, 8'd1,  CHK_PREDICT},
      // 34-character label, cut to the limit and flagged
      '{8'h4C,              1'b1, 1'b0, 16'h5AA5, 8'd1,  CHK_PREDICT},
      '{8'h4C,              1'b0, 1'b0, 16'h0000, 8'd33, CHK_NONE},
      '{dqpb_pkg::SEP_CHAR, 1'b0, 1'b0, 16'h0000, 8'd1,  CHK_PREDICT},
      // exactly at the limit, closed by the last character: no flag
      '{8'h6D,              1'b0, 1'b0, 16'h0000, 8'd31, CHK_NONE},
      '{8'h6E,              1'b0, 1'b1, 16'h0000, 8'd1,  CHK_PREDICT},
      // first and last on the same character
      '{8'h7A,              1'b1, 1'b1, 16'hA5A5, 8'd1,  CHK_PREDICT},
      '{8'h80,              1'b1, 1'b0, 16'h00FF, 8'd1,  CHK_PREDICT},
      '{8'h7F,              1'b0, 1'b1, 16'hFF00, 8'd1,  CHK_PREDICT}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, register defaults, no idling
    foreach (dir_rows[r]) begin
      it = name_item_t'{dir_rows[r].ch, dir_rows[r].first, dir_rows[r].last,
                        dir_rows[r].qid};
      repeat (dir_rows[r].rep) send_char(it, dir_rows[r].kind);
    end
    s_tvalid <= 1'b0;

    // random part in four register settings, extremes among them
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_registers(16'($urandom), 16'($urandom), 16'($urandom));
        1:       set_registers(16'h0000, 16'h0000, 16'h0000);
        2:       set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_registers(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      // first setting runs with no idling on either side
      tx_idle = (ph != 0);
      rx_idle = (ph != 0);
      // the receiver holds off long enough for the block to back up its input
      if (ph == 1) hold_ask = hold_ask + 1;
      phase_start = items_sent;
      while (items_sent - phase_start < RAND_ITEMS / 4) begin
        // once, the sender waits until every owed beat has arrived
        if (ph == 2 && !paused && items_sent - phase_start > 5) begin
          s_tvalid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 99) < 85) begin
          send_random_name();
        end else begin
          // noise: any byte, flags set at random
          it = name_item_t'{8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 3) == 0, 16'($urandom)};
          send_char(it, CHK_PREDICT);
        end
      end
      s_tvalid <= 1'b0;
    end

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0)
      $display("dns_query_packet_builder: match");
    else
      $display("dns_query_packet_builder: mismatch");
    $finish;
  end

endmodule
